[rtl/slsfr_pkg.sv]
// Shared types and constants for the sync/length/checksum frame receiver.
`default_nettype none

package slsfr_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] kind_t;

	// Result kinds.
	localparam kind_t KIND_DATA   = 3'd0;
	localparam kind_t KIND_GOOD   = 3'd1;
	localparam kind_t KIND_OTHER  = 3'd2;
	localparam kind_t KIND_CSERR  = 3'd3;
	localparam kind_t KIND_BADLEN = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
	localparam logic [1:0] REG_ACCEPTED_TYPE = 2'd2;

	// Frame overhead: two sync bytes, the length byte and the checksum byte.
	localparam byte_t FRAME_OVERHEAD = 8'd4;
	// Shortest length that leaves room for the type byte.
	localparam byte_t MIN_LENGTH     = 8'd5;
	localparam byte_t SUM_START      = 8'h00;

endpackage

`default_nettype wire

[rtl/sync_length_sum_frame_receiver_unit.sv]
// A taken byte enters the input register, then any result it gives enters the result register.
// Throughput: one byte per cycle unless out_stall holds a full result register; the parser
// state registers update once per byte; the result register refills while it is being taken.
// Reset: arst_n clears the parser to hunting for the first sync byte, zeroes the counters,
// the running sum and all configuration registers, and empties both stages.
`default_nettype none

module sync_length_sum_frame_receiver_unit
	import slsfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// Received byte channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	// Result channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [7:0]       data_byte,
	output logic [7:0]       byte_index,
	output logic [7:0]       frame_type,
	output logic             frame_end
);

	// Parser phases.
	localparam logic [2:0] PH_SYNC1   = 3'd0;
	localparam logic [2:0] PH_SYNC2   = 3'd1;
	localparam logic [2:0] PH_LENGTH  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CHECK   = 3'd4;

	byte_t       sync_first_q;
	byte_t       sync_second_q;
	byte_t       accepted_type_q;

	logic        v_s1;
	byte_t       byte_s1;

	logic [2:0]  phase_q, phase_d;
	byte_t       bytes_left_q, bytes_left_d;
	byte_t       position_q, position_d;
	byte_t       sum_q, sum_d;
	byte_t       type_q, type_d;

	logic        out_valid_q;
	kind_t       kind_q;
	byte_t       data_q, index_q, ftype_q;
	logic        fend_q;

	logic        res_valid;
	kind_t       res_kind;
	byte_t       res_data, res_index, res_ftype;
	logic        res_fend;

	logic        can_take;
	logic        proc;
	logic        in_acc;

	// The result register can take a new request when it is empty or being drained.
	assign can_take = !out_valid_q || !out_stall;
	assign proc     = v_s1 && can_take;
	assign in_stall = v_s1 && !can_take;
	assign in_acc   = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q    <= 8'd0;
			sync_second_q   <= 8'd0;
			accepted_type_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:    sync_first_q    <= cfg_data;
				REG_SYNC_SECOND:   sync_second_q   <= cfg_data;
				REG_ACCEPTED_TYPE: accepted_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	// Parser: next state and result for the byte in the input register.
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		position_d   = position_q;
		sum_d        = sum_q;
		type_d       = type_q;
		res_valid    = 1'b0;
		res_kind     = KIND_DATA;
		res_data     = 8'd0;
		res_index    = 8'd0;
		res_ftype    = 8'd0;
		res_fend     = 1'b0;
		unique case (phase_q)
			PH_SYNC2: begin
				if (byte_s1 == sync_second_q) begin
					sum_d   = sum_q + byte_s1;
					phase_d = PH_LENGTH;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_LENGTH: begin
				if (byte_s1 < MIN_LENGTH) begin
					phase_d   = PH_SYNC1;
					res_valid = 1'b1;
					res_kind  = KIND_BADLEN;
					res_fend  = 1'b1;
				end else begin
					sum_d        = sum_q + byte_s1;
					bytes_left_d = byte_s1 - FRAME_OVERHEAD;
					position_d   = 8'd0;
					type_d       = 8'd0;
					phase_d      = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (position_q == 8'd0) begin
					type_d = byte_s1;
				end
				sum_d        = sum_q + byte_s1;
				position_d   = position_q + 8'd1;
				bytes_left_d = bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					phase_d = PH_CHECK;
				end
				res_valid = 1'b1;
				res_kind  = KIND_DATA;
				res_data  = byte_s1;
				res_index = position_q;
			end
			PH_CHECK: begin
				if (byte_s1 != sum_q) begin
					res_kind = KIND_CSERR;
				end else if (type_q == accepted_type_q) begin
					res_kind = KIND_GOOD;
				end else begin
					res_kind = KIND_OTHER;
				end
				phase_d   = PH_SYNC1;
				res_valid = 1'b1;
				res_ftype = type_q;
				res_fend  = 1'b1;
			end
			default: begin
				// Hunting for the first sync byte; unused codes land here too.
				if (byte_s1 == sync_first_q) begin
					sum_d   = byte_s1;
					phase_d = PH_SYNC2;
				end else begin
					sum_d   = SUM_START;
					phase_d = PH_SYNC1;
				end
			end
		endcase
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SYNC1;
			bytes_left_q <= 8'd0;
			position_q   <= 8'd0;
			sum_q        <= 8'd0;
			type_q       <= 8'd0;
		end else if (proc) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			position_q   <= position_d;
			sum_q        <= sum_d;
			type_q       <= type_d;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			kind_q  <= res_kind;
			data_q  <= res_data;
			index_q <= res_index;
			ftype_q <= res_ftype;
			fend_q  <= res_fend;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign byte_index = index_q;
	assign frame_type = ftype_q;
	assign frame_end  = fend_q;

`ifndef NO_ASSERTIONS
	// A verdict always closes a frame, and a payload byte never does.
	a_end_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end == (kind != KIND_DATA)))
		else $error("frame_end does not match the result kind");

	// While in the payload phase at least one payload byte is still expected.
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (bytes_left_q != 8'd0))
		else $error("payload phase with no bytes left");

	// The input is held off only while a byte waits behind a blocked result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// A payload byte result comes only from the payload phase.
	a_data_from_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && res_valid && (res_kind == KIND_DATA)) |-> (phase_q == PH_PAYLOAD))
		else $error("payload byte result outside the payload phase");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the sync/length/checksum frame receiver.
`default_nettype none

module testbench;
	import slsfr_pkg::*;

	// Parser phases of the frame predictor.
	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		TAKE_LENGTH,
		TAKE_PAYLOAD,
		TAKE_CHECKSUM
	} parse_phase_e;

	typedef enum logic {
		ROW_BYTE,
		ROW_CFG
	} row_op_e;

	typedef struct packed {
		kind_t kind;
		byte_t data;
		byte_t pos;
		byte_t ftype;
		logic  last;
	} frame_result_t;

	typedef struct packed {
		row_op_e       op;
		logic [1:0]    reg_sel;
		byte_t         value;
		logic          typed;
		frame_result_t want;
	} stim_row_t;

	localparam frame_result_t NO_RESULT = '0;
	localparam int PHASE_ITEMS = 140;
	localparam int SETTLE_CYCLES = 4;

	// Directed requests: reset settings, sync mismatches, length extremes, every verdict but other type.
	localparam stim_row_t DIRECTED [28] = '{
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h05, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h00, 1'b1, '{KIND_DATA, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h05, 1'b1, '{KIND_GOOD, 8'h00, 8'h00, 8'h00, 1'b1}},
		'{ROW_CFG, REG_SYNC_FIRST, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_SYNC_SECOND, 8'h55, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_ACCEPTED_TYPE, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h12, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h13, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h04, 1'b1, '{KIND_BADLEN, 8'h00, 8'h00, 8'h00, 1'b1}},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h00, 1'b1, '{KIND_BADLEN, 8'h00, 8'h00, 8'h00, 1'b1}},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h06, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'hFF, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h04, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'hAA, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h55, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h05, 1'b0, NO_RESULT},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h7E, 1'b1, '{KIND_DATA, 8'h7E, 8'h00, 8'h00, 1'b0}},
		'{ROW_BYTE, REG_SYNC_FIRST, 8'h83, 1'b1, '{KIND_CSERR, 8'h00, 8'h00, 8'h7E, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_SYNC_FIRST;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic [7:0]  frame_type;
	logic        frame_end;

	// Predictor state and its copy of the registers.
	parse_phase_e parser_phase = HUNT_FIRST;
	byte_t        payload_left = '0;
	byte_t        payload_pos = '0;
	byte_t        frame_sum = SUM_START;
	byte_t        frame_type_seen = '0;
	byte_t        sync_first_cfg = '0;
	byte_t        sync_second_cfg = '0;
	byte_t        accept_type_cfg = '0;

	frame_result_t expected_results [$];
	int            mismatches = 0;
	int            bytes_sent = 0;
	int            results_seen = 0;
	int            kind_count [8];
	bit            idle_on = 1'b1;

	sync_length_sum_frame_receiver_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.frame_type (frame_type),
		.frame_end  (frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the frame parser by one received byte; returns 1 when a result is due.
	function automatic bit parse_byte(input byte_t b, output frame_result_t r);
		r = NO_RESULT;
		case (parser_phase)
			HUNT_SECOND: begin
				if (b == sync_second_cfg) begin
					frame_sum = frame_sum + b;
					parser_phase = TAKE_LENGTH;
				end else begin
					parser_phase = HUNT_FIRST;
				end
				return 1'b0;
			end
			TAKE_LENGTH: begin
				if (b < MIN_LENGTH) begin
					parser_phase = HUNT_FIRST;
					r.kind = KIND_BADLEN;
					r.last = 1'b1;
					return 1'b1;
				end
				frame_sum = frame_sum + b;
				payload_left = b - FRAME_OVERHEAD;
				payload_pos = '0;
				frame_type_seen = '0;
				parser_phase = TAKE_PAYLOAD;
				return 1'b0;
			end
			TAKE_PAYLOAD: begin
				if (payload_pos == 8'd0)
					frame_type_seen = b;
				frame_sum = frame_sum + b;
				r.kind = KIND_DATA;
				r.data = b;
				r.pos = payload_pos;
				payload_pos = payload_pos + 8'd1;
				payload_left = payload_left - 8'd1;
				if (payload_left == 8'd0)
					parser_phase = TAKE_CHECKSUM;
				return 1'b1;
			end
			TAKE_CHECKSUM: begin
				if (b != frame_sum)
					r.kind = KIND_CSERR;
				else if (frame_type_seen == accept_type_cfg)
					r.kind = KIND_GOOD;
				else
					r.kind = KIND_OTHER;
				r.ftype = frame_type_seen;
				r.last = 1'b1;
				parser_phase = HUNT_FIRST;
				return 1'b1;
			end
			default: begin
				frame_sum = SUM_START;
				parser_phase = HUNT_FIRST;
				if (b == sync_first_cfg) begin
					frame_sum = b;
					parser_phase = HUNT_SECOND;
				end
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Offer one byte, hold it until taken, then record what it should produce.
	task automatic send_request(input byte_t b, input logic typed, input frame_result_t want);
		frame_result_t r;
		bit produced;
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		produced = parse_byte(b, r);
		if (typed)
			expected_results.push_back(want);
		else if (produced)
			expected_results.push_back(r);
		if (idle_on && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 24);
		end
	endtask

	// Stop sending and let every expected result drain out of the block.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] sel, input byte_t val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (sel)
			REG_SYNC_FIRST:    sync_first_cfg = val;
			REG_SYNC_SECOND:   sync_second_cfg = val;
			REG_ACCEPTED_TYPE: accept_type_cfg = val;
			default: ;
		endcase
	endtask

	// One frame with random content; mostly good checksums, some bad lengths.
	task automatic send_frame(input bit longest);
		byte_t len;
		byte_t sum;
		byte_t b;
		int pick;
		pick = $urandom_range(99);
		if (longest)
			len = 8'hFF;
		else if (pick < 8)
			len = byte_t'($urandom_range(0, 4));
		else if (pick < 12)
			len = byte_t'($urandom_range(13, 40));
		else
			len = byte_t'($urandom_range(5, 12));
		send_request(sync_first_cfg, 1'b0, NO_RESULT);
		send_request(sync_second_cfg, 1'b0, NO_RESULT);
		send_request(len, 1'b0, NO_RESULT);
		if (len < MIN_LENGTH)
			return;
		sum = sync_first_cfg + sync_second_cfg + len;
		for (int i = 0; i < int'(len - FRAME_OVERHEAD); i++) begin
			b = (i == 0 && $urandom_range(1)) ? accept_type_cfg : byte_t'($urandom);
			send_request(b, 1'b0, NO_RESULT);
			sum = sum + b;
		end
		if ($urandom_range(99) < 15)
			sum = sum ^ byte_t'($urandom_range(1, 255));
		send_request(sum, 1'b0, NO_RESULT);
	endtask

	// Result side: random stalls except in the stretch with no idling.
	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 24);
	end

	// Compare each taken result with the oldest expectation.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			kind_count[kind]++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result kind %0d with nothing expected", kind));
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (data_byte !== want.data)
					report_mismatch($sformatf("data_byte %h, expected %h", data_byte, want.data));
				if (byte_index !== want.pos)
					report_mismatch($sformatf("byte_index %0d, expected %0d", byte_index,
						want.pos));
				if (frame_type !== want.ftype)
					report_mismatch($sformatf("frame_type %h, expected %h", frame_type,
						want.ftype));
				if (frame_end !== want.last)
					report_mismatch($sformatf("frame_end %b, expected %b", frame_end, want.last));
			end
		end
	end

	// Stimulus: directed table, then phases of random traffic under different settings.
	initial begin
		byte_t s1;
		byte_t s2;
		byte_t at;
		int start;
		int pick;
		byte_t b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].op == ROW_CFG) begin
				settle_block();
				write_register(DIRECTED[i].reg_sel, DIRECTED[i].value);
			end else begin
				send_request(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		for (int p = 0; p < 5; p++) begin
			settle_block();
			s1 = byte_t'($urandom);
			s2 = byte_t'($urandom);
			at = byte_t'($urandom);
			case (p)
				0: begin
					s1 = 8'h00;
					s2 = 8'h00;
					at = 8'h00;
				end
				1: begin
					s1 = 8'hFF;
					s2 = 8'hFF;
					at = 8'hFF;
				end
				3: s2 = s1;
				default: ;
			endcase
			write_register(REG_SYNC_FIRST, s1);
			write_register(REG_SYNC_SECOND, s2);
			write_register(REG_ACCEPTED_TYPE, at);
			idle_on = (p != 1);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (p == 2 && bytes_sent == start) begin
					send_frame(1'b1);
				end else if (pick < 70) begin
					send_frame(1'b0);
				end else if (pick < 85) begin
					// Line noise that never looks like a first sync byte.
					b = byte_t'($urandom);
					if (b == sync_first_cfg)
						b = b ^ 8'h01;
					send_request(b, 1'b0, NO_RESULT);
				end else begin
					// Broken header: the first sync byte, then anything but the second.
					send_request(sync_first_cfg, 1'b0, NO_RESULT);
					b = byte_t'($urandom);
					if (sync_first_cfg != sync_second_cfg && $urandom_range(1))
						b = sync_first_cfg;
					if (b == sync_second_cfg)
						b = b ^ 8'h01;
					send_request(b, 1'b0, NO_RESULT);
				end
			end
		end

		idle_on = 1'b1;
		settle_block();
		repeat (8) @(posedge clk);
		$display("covered %0d received bytes and %0d results under 6 register settings",
			bytes_sent, results_seen);
		$display("payload %0d, accepted %0d, other type %0d, checksum error %0d, bad length %0d",
			kind_count[KIND_DATA], kind_count[KIND_GOOD], kind_count[KIND_OTHER],
			kind_count[KIND_CSERR], kind_count[KIND_BADLEN]);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
